// ===== rtl/core/merge_sorter_defines.svh =====
// Assertion macros for the merge sorter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MERGE_SORTER_DEFINES_SVH
`define MERGE_SORTER_DEFINES_SVH

`define MS_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define MS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/ms_pkg.sv =====
// Shared types and constants for the merge sorter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ms_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t                 mode;
    logic signed [DATA_W-1:0]   new_value;
  } cell_ctrl_t;

  typedef struct packed {
    logic                       keep;
    logic                       valid;
    logic signed [DATA_W-1:0]   value;
  } cell_link_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } ms_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/merge_sorter.sv =====
// Stable ascending sorter of signed 32-bit lists, top level.
// Depends on ms_pkg, ms_cell and merge_sorter_defines.svh.
//
// Input channel in_*: one element per item; in_tlast marks the last element.
// Each accepted element is placed into a row of 64 slots that stays sorted.
// Equal elements keep arrival order.
// Elements beyond 64 are dropped and the run is flagged on out_tuser.
// In the cycle after the last element is accepted, the sorted run streams out
// on out_*, one item per cycle while out_tready is high, with out_tlast on
// the final item; the row shifts one slot per emitted item.
// in_tready is low while a run is being emitted. When the receiver stalls,
// the row and the output hold. Reset clears all valid bits and counters and
// returns to loading; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] sample_value
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [31:0] sorted_value
  output      logic        out_tlast,
  output      logic        out_tuser   // [0] truncated
);
  import ms_pkg::*;
  `include "merge_sorter_defines.svh"

  ms_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] emit_left_r, emit_left_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_fire, out_fire, full;
  cell_ctrl_t       ctrl;
  cell_link_t       links [CAPACITY];
  cell_link_t       head_bound, tail_bound;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign full     = (count_r == CNT_W'(CAPACITY));

  assign head_bound = '{keep: 1'b1, valid: 1'b0, value: '0};
  assign tail_bound = '{keep: 1'b0, valid: 1'b0, value: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      ms_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_link  (head_bound),
        .right_link (links[i+1]),
        .link       (links[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      ms_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_link  (links[i-1]),
        .right_link (tail_bound),
        .link       (links[i])
      );
    end else begin : g_mid
      ms_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_link  (links[i-1]),
        .right_link (links[i+1]),
        .link       (links[i])
      );
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    emit_left_nxt  = emit_left_r;
    ovf_nxt        = ovf_r;
    ctrl.mode      = CELL_HOLD;
    ctrl.new_value = $signed(in_tdata);
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_fire) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctrl.mode = CELL_INSERT;
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            state_nxt     = ST_EMIT;
            emit_left_nxt = count_nxt;
          end
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_fire) begin
          ctrl.mode     = CELL_SHIFT;
          emit_left_nxt = emit_left_r - 1'b1;
          if (emit_left_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      emit_left_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emit_left_r <= emit_left_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  assign out_tdata = links[0].value;
  assign out_tlast = (emit_left_r == CNT_W'(1));
  assign out_tuser = ovf_r;

  `MS_ASSERT_NOW(a_no_overlap, !(in_tready && out_tvalid), "load and emit overlap")
  `MS_ASSERT_NEXT(a_emit_after_last, in_fire && in_tlast, out_tvalid && links[0].valid,
                  "no sorted item after last input")
  `MS_ASSERT_NEXT(a_clear_after_run, out_fire && out_tlast,
                  in_tready && (count_r == '0) && !links[0].valid, "state not cleared after run")
  `MS_ASSERT_NEXT(a_ascending, out_fire && !out_tlast,
                  out_tvalid && ($signed($past(out_tdata)) <= $signed(out_tdata)),
                  "output not ascending")

endmodule

`default_nettype wire

// ===== rtl/core/ms_cell.sv =====
// One slot of the sorted chain: holds one element and its valid bit.
// Depends on ms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ms_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ms_pkg::cell_ctrl_t ctrl,
  input  wire ms_pkg::cell_link_t left_link,
  input  wire ms_pkg::cell_link_t right_link,
  output      ms_pkg::cell_link_t link
);
  import ms_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     keep;

  // keep: this slot holds an element that sorts at or before the new one
  assign keep = valid_r && (value_r <= ctrl.new_value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    case (ctrl.mode)
      CELL_INSERT: begin
        if (!keep) begin
          if (left_link.keep) begin
            valid_nxt = 1'b1;
            value_nxt = ctrl.new_value;
          end else begin
            valid_nxt = left_link.valid;
            value_nxt = left_link.value;
          end
        end
      end
      CELL_SHIFT: begin
        valid_nxt = right_link.valid;
        value_nxt = right_link.value;
      end
      default: begin
        valid_nxt = valid_r;
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link.keep  = keep;
  assign link.valid = valid_r;
  assign link.value = value_r;

endmodule

`default_nettype wire
